FILE: src/unsigned_128bit_divider_assert.svh
// Assertion macros used by the divider's top-level RTL file.
`ifndef UNSIGNED_128BIT_DIVIDER_ASSERT_SVH
`define UNSIGNED_128BIT_DIVIDER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UDIV128_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("divider assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define UDIV128_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("divider assertion failed");

`endif

FILE: src/udiv128_pkg.sv
// Shared widths and controller-to-datapath command type for the divider.
package udiv128_pkg;

   localparam int HALF_WIDTH  = 64;
   localparam int WIDTH       = 2 * HALF_WIDTH;
   localparam int CNT_WIDTH   = $clog2(WIDTH);
   localparam int TDATA_WIDTH = 4 * HALF_WIDTH;

   typedef struct packed {
      logic load;     // take a new operand pair
      logic step;     // run one restoring iteration
      logic capture;  // move the finished result into the output register
   } udiv128_cmd_type;

endpackage

FILE: src/udiv128_dp.sv
// Datapath of the divider: operand, partial remainder and quotient registers.
module udiv128_dp
   import udiv128_pkg::*;
(
   input  logic                   clock,
   input  udiv128_cmd_type        cmd,
   input  logic [TDATA_WIDTH-1:0] req_tdata,
   output logic [TDATA_WIDTH-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic             dbz_ff, dbz_in;
   logic [WIDTH-1:0] out_quo_ff, out_quo_in;
   logic [WIDTH-1:0] out_rem_ff, out_rem_in;
   logic             out_dbz_ff, out_dbz_in;

   logic [WIDTH:0]   partial;
   logic [WIDTH:0]   diff;
   logic             take;
   logic [WIDTH-1:0] new_den;

   // Field order on req_tdata: dividend_high, dividend_low, divisor_high, divisor_low.
   assign new_den = {req_tdata[3*HALF_WIDTH-1:2*HALF_WIDTH],
                     req_tdata[4*HALF_WIDTH-1:3*HALF_WIDTH]};

   // Bring down the next dividend bit; a set top bit means the subtract always fits.
   assign partial = {rem_ff, num_ff[WIDTH-1]};
   assign diff    = partial - {1'b0, den_ff};
   assign take    = ~diff[WIDTH];

   always_comb begin
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dbz_in     = dbz_ff;
      out_quo_in = out_quo_ff;
      out_rem_in = out_rem_ff;
      out_dbz_in = out_dbz_ff;
      if (cmd.load) begin
         num_in = {req_tdata[HALF_WIDTH-1:0], req_tdata[2*HALF_WIDTH-1:HALF_WIDTH]};
         den_in = new_den;
         rem_in = '0;
         quo_in = '0;
         dbz_in = (new_den == '0);
      end else if (cmd.step) begin
         num_in = {num_ff[WIDTH-2:0], 1'b0};
         rem_in = take ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], take};
      end
      if (cmd.capture) begin
         // Zero divisor: report zeros with the flag set.
         out_quo_in = dbz_ff ? '0 : quo_ff;
         out_rem_in = dbz_ff ? '0 : rem_ff;
         out_dbz_in = dbz_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dbz_ff     <= dbz_in;
      out_quo_ff <= out_quo_in;
      out_rem_ff <= out_rem_in;
      out_dbz_ff <= out_dbz_in;
   end

   assign rsp_tdata = {out_rem_ff[HALF_WIDTH-1:0], out_rem_ff[WIDTH-1:HALF_WIDTH],
                       out_quo_ff[HALF_WIDTH-1:0], out_quo_ff[WIDTH-1:HALF_WIDTH]};
   assign rsp_tuser = out_dbz_ff;

endmodule

FILE: src/udiv128_ctrl.sv
// Controller of the divider: accept, iteration count and result handoff.
module udiv128_ctrl
   import udiv128_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output udiv128_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 valid_ff, valid_in;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_WIDTH'(WIDTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free or being drained.
            if (!valid_ff || rsp_tready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

FILE: src/unsigned_128bit_divider.sv
// Top level of the 128-bit unsigned restoring divider.
// Divides a 128-bit unsigned dividend by a 128-bit unsigned divisor and returns
// quotient and remainder; a zero divisor returns zeros with the divide_by_zero
// flag in rsp_tuser. The accepting cycle loads the operands, 128 iterations of the
// single 129-bit subtract and compare unit follow (one quotient bit each), and a
// final capture step moves the result into the output register. A new word is
// accepted only once the result has moved to the output register, so the divider
// cannot take a new word while one is in progress; a result still waiting in the
// output register holds the next word after its 128 iterations until the sink
// drains it.
module unsigned_128bit_divider
   import udiv128_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // dividend_high[63:0], dividend_low[127:64], divisor_high[191:128], divisor_low[255:192]
   input  logic [TDATA_WIDTH-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // quotient_high[63:0], quotient_low[127:64], remainder_high[191:128],
   // remainder_low[255:192]
   output logic [TDATA_WIDTH-1:0] rsp_tdata,
   // divide_by_zero[0]
   output logic                   rsp_tuser
);

`include "unsigned_128bit_divider_assert.svh"

   udiv128_cmd_type cmd;

   udiv128_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   udiv128_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   `UDIV128_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `UDIV128_ASSERT_SAME(a_no_accept_while_iterating, clock, reset, cmd.step, !req_tready)
   `UDIV128_ASSERT_SAME(a_dbz_zero_data, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `UDIV128_ASSERT_NEXT(a_capture_sets_valid, clock, reset, cmd.capture, rsp_tvalid)

endmodule

FILE: tb/tb.sv
// Testbench for the 128-bit unsigned divider: stream stimulus, result prediction and checking.
`timescale 1ns / 100ps

module tb;
   import udiv128_pkg::*;

   typedef struct {
      logic [HALF_WIDTH-1:0] quo_hi;
      logic [HALF_WIDTH-1:0] quo_lo;
      logic [HALF_WIDTH-1:0] rem_hi;
      logic [HALF_WIDTH-1:0] rem_lo;
      logic                  by_zero;
   } div_result_type;

   typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_RUNS} sink_mode_type;

   localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
   localparam logic [WIDTH-1:0] ONE      = {{(WIDTH-1){1'b0}}, 1'b1};
   localparam int DRAIN_CYCLES = 140;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_WIDTH-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_WIDTH-1:0] rsp_tdata;
   logic                   rsp_tuser;

   div_result_type pending_results[$];
   int             mismatch_count = 0;
   int             burst_left = 1;
   bit             sender_eager = 1'b0;
   int             rsp_hold_cycles = 0;
   int             pattern_left = 0;
   sink_mode_type  sink_mode = SINK_OPEN;

   unsigned_128bit_divider u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic div_result_type predict_division(input logic [WIDTH-1:0] dividend,
                                                       input logic [WIDTH-1:0] divisor);
      div_result_type   res;
      logic [WIDTH-1:0] quo;
      logic [WIDTH-1:0] rem;
      if (divisor == '0) begin
         quo = '0;
         rem = '0;
         res.by_zero = 1'b1;
      end else begin
         quo = dividend / divisor;
         rem = dividend % divisor;
         res.by_zero = 1'b0;
      end
      res.quo_hi = quo[WIDTH-1:HALF_WIDTH];
      res.quo_lo = quo[HALF_WIDTH-1:0];
      res.rem_hi = rem[WIDTH-1:HALF_WIDTH];
      res.rem_lo = rem[HALF_WIDTH-1:0];
      return res;
   endfunction

   function automatic logic [WIDTH-1:0] random_wide();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // Random value of random bit length, so small and large operands both show up.
   function automatic logic [WIDTH-1:0] random_sized();
      return random_wide() >> $urandom_range(0, WIDTH - 1);
   endfunction

   task automatic issue_division(input logic [WIDTH-1:0] dividend,
                                 input logic [WIDTH-1:0] divisor);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor[HALF_WIDTH-1:0], divisor[WIDTH-1:HALF_WIDTH],
                     dividend[HALF_WIDTH-1:0], dividend[WIDTH-1:HALF_WIDTH]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_division(dividend, divisor));
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = sender_eager ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      issue_division('0, ONE);
      issue_division('0, '0);
      issue_division(ALL_ONES, '0);
      issue_division(ALL_ONES, ONE);
      issue_division(ALL_ONES, ALL_ONES);
      issue_division(ALL_ONES, ALL_ONES - 1);
      issue_division(ONE, ALL_ONES);
      issue_division(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                     128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
      issue_division(ALL_ONES, ONE << (WIDTH - 1));
      issue_division(ALL_ONES, ONE << HALF_WIDTH);
      issue_division(ALL_ONES, ONE << (HALF_WIDTH - 1));
      issue_division(ALL_ONES, 128'd2);
      issue_division(ONE << (WIDTH - 1), 128'd3);
      issue_division(ONE << HALF_WIDTH, (ONE << HALF_WIDTH) - 1);
      issue_division(ALL_ONES, (ONE << HALF_WIDTH) + 1);
      issue_division(ALL_ONES, ALL_ONES >> HALF_WIDTH);
      issue_division(128'hdead_beef_0000_0001_0000_0000_0000_0000,
                     128'h0000_0000_0000_0000_0000_0000_0000_0007);
      issue_division(128'd12345, 128'd10);
      // divisor above 2^127: the partial remainder overflows its top bit
      issue_division(ALL_ONES, (ONE << (WIDTH - 1)) + 1);
      issue_division((ONE << (WIDTH - 1)) + 128'd5, ALL_ONES);
      issue_division(ALL_ONES - 1, ALL_ONES >> 1);
      issue_division(128'h8000_0000_0000_0000_8000_0000_0000_0000,
                     128'h0000_0000_0000_0001_0000_0000_0000_0000);
   endtask

   // Hold the sink off long enough for the divider to fill up and stall its input.
   task automatic test_backpressure();
      int i;
      rsp_hold_cycles = 1500;
      for (i = 0; i < 6; i++) issue_division(random_wide(), random_sized());
      wait_for_results();
   endtask

   task automatic test_random(input int count);
      int               i;
      int               kind;
      logic [WIDTH-1:0] dividend;
      logic [WIDTH-1:0] divisor;
      for (i = 0; i < count; i++) begin
         if (i % 100 == 0) sender_eager = ($urandom_range(0, 3) == 0);
         if (i == count / 2) wait_for_results();
         kind = $urandom_range(0, 19);
         dividend = random_sized();
         divisor  = random_sized();
         case (kind)
            0, 1, 2, 3, 4, 5: ;
            6, 7: dividend = random_wide();
            8, 9: divisor = ONE << $urandom_range(0, WIDTH - 1);
            10: divisor = ONE;
            11: divisor = dividend;
            12, 13: begin
               divisor = random_wide();
               dividend = divisor >> $urandom_range(1, WIDTH - 1);
            end
            14: divisor = '0;
            15: begin
               divisor = random_wide() | (ONE << (WIDTH - 1));
               dividend = random_wide();
            end
            16: divisor = random_wide() >> HALF_WIDTH;
            default: begin
               dividend = random_wide();
               divisor = random_wide();
            end
         endcase
         issue_division(dividend, divisor);
      end
      sender_eager = 1'b0;
   endtask

   // Sink: ready pattern changes at random, with a forced hold-off when requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 300);
         end
         pattern_left--;
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            case (sink_mode)
               SINK_OPEN:   rsp_tready <= 1'b1;
               SINK_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
               SINK_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
               default:     rsp_tready <= ((pattern_left % 16) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      div_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no division pending");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[HALF_WIDTH-1:0] !== want.quo_hi) begin
               $error("quotient_high expected %h got %h", want.quo_hi,
                      rsp_tdata[HALF_WIDTH-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[2*HALF_WIDTH-1:HALF_WIDTH] !== want.quo_lo) begin
               $error("quotient_low expected %h got %h", want.quo_lo,
                      rsp_tdata[2*HALF_WIDTH-1:HALF_WIDTH]);
               mismatch_count++;
            end
            if (rsp_tdata[3*HALF_WIDTH-1:2*HALF_WIDTH] !== want.rem_hi) begin
               $error("remainder_high expected %h got %h", want.rem_hi,
                      rsp_tdata[3*HALF_WIDTH-1:2*HALF_WIDTH]);
               mismatch_count++;
            end
            if (rsp_tdata[4*HALF_WIDTH-1:3*HALF_WIDTH] !== want.rem_lo) begin
               $error("remainder_low expected %h got %h", want.rem_lo,
                      rsp_tdata[4*HALF_WIDTH-1:3*HALF_WIDTH]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.by_zero) begin
               $error("divide_by_zero expected %b got %b", want.by_zero, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(750);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/udiv128_pkg.sv
src/udiv128_dp.sv
src/udiv128_ctrl.sv
src/unsigned_128bit_divider.sv
tb/tb.sv
